FILE: hdl/trapezoid_fuzzy_membership_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the trapezoid fuzzy membership block
// Clocked on clk_i, held off while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef TRAPEZOID_FUZZY_MEMBERSHIP_MACROS_SVH
`define TRAPEZOID_FUZZY_MEMBERSHIP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define TFM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define TFM_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition seen");
`else
`define TFM_ASSERT(lbl, prop)
`define TFM_ASSERT_NEVER(lbl, expr)
`endif

`endif

FILE: hdl/tfm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tfm_pkg
// Shared types and constants of the trapezoid fuzzy membership block.
// ---------------------------------------------------------------------------
package tfm_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned REG_IDX_W     = 2;

  localparam logic [REG_IDX_W-1:0] REG_LEFT_FOOT      = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_LEFT_SHOULDER  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_RIGHT_SHOULDER = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_RIGHT_FOOT     = 2'd3;

  // what the final grade is made of
  typedef enum logic [1:0] {
    KIND_ZERO = 2'b00,
    KIND_ONE  = 2'b01,
    KIND_DIV  = 2'b10
  } tfm_kind_e;

  typedef struct packed {
    logic      valid;
    tfm_kind_e kind;
  } tfm_ctl_t;

endpackage

FILE: hdl/tfm_classify.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tfm_classify
// Region test of the sample against the breakpoints; sets up the
// numerator and divisor of the edge slope. One register stage.
// ---------------------------------------------------------------------------
module tfm_classify #(
  parameter int unsigned FRAC_BITS = tfm_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [FRAC_BITS:0]   x_i,
  input  logic [FRAC_BITS:0]   a_i,
  input  logic [FRAC_BITS:0]   b_i,
  input  logic [FRAC_BITS:0]   c_i,
  input  logic [FRAC_BITS:0]   d_i,
  output tfm_pkg::tfm_ctl_t    ctl_o,
  output logic [FRAC_BITS:0]   num_o,
  output logic [FRAC_BITS:0]   den_o
);
  import tfm_pkg::*;

  localparam int unsigned W = FRAC_BITS + 1;

  tfm_ctl_t       ctl_d, ctl_q;
  logic [W-1:0]   num_d, num_q, den_d, den_q;
  logic           plateau, outside, rising;

  always_comb begin
    plateau = (x_i >= b_i) && (x_i <= c_i);
    outside = (x_i <= a_i) || (x_i >= d_i);
    rising  = x_i < b_i;
    ctl_d.valid = valid_i;
    if (plateau) begin
      ctl_d.kind = KIND_ONE;
    end else if (outside) begin
      ctl_d.kind = KIND_ZERO;
    end else begin
      ctl_d.kind = KIND_DIV;
    end
    // num < den holds whenever the divide path is taken
    num_d = rising ? (x_i - a_i) : (d_i - x_i);
    den_d = rising ? (b_i - a_i) : (d_i - c_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '{valid: 1'b0, kind: KIND_ZERO};
    end else if (en_i) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= num_d;
      den_q <= den_d;
    end
  end

  assign ctl_o = ctl_q;
  assign num_o = num_q;
  assign den_o = den_q;

endmodule

FILE: hdl/tfm_div_stage.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tfm_div_stage
// One restoring-division step: produces one quotient bit per stage.
// ---------------------------------------------------------------------------
module tfm_div_stage #(
  parameter int unsigned FRAC_BITS = tfm_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  tfm_pkg::tfm_ctl_t      ctl_i,
  input  logic [FRAC_BITS:0]     rem_i,
  input  logic [FRAC_BITS:0]     den_i,
  input  logic [FRAC_BITS-1:0]   quo_i,
  output tfm_pkg::tfm_ctl_t      ctl_o,
  output logic [FRAC_BITS:0]     rem_o,
  output logic [FRAC_BITS:0]     den_o,
  output logic [FRAC_BITS-1:0]   quo_o
);
  import tfm_pkg::*;

  localparam int unsigned W = FRAC_BITS + 1;

  tfm_ctl_t               ctl_q;
  logic [W-1:0]           rem_d, rem_q, den_q;
  logic [FRAC_BITS-1:0]   quo_d, quo_q;
  logic [W:0]             shl;
  logic [W+1:0]           diff;
  logic                   take;

  always_comb begin
    shl   = {rem_i, 1'b0};
    diff  = {1'b0, shl} - {2'b00, den_i};
    take  = ~diff[W+1];
    rem_d = take ? diff[W-1:0] : shl[W-1:0];
    quo_d = {quo_i[FRAC_BITS-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '{valid: 1'b0, kind: KIND_ZERO};
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      den_q <= den_i;
      quo_q <= quo_d;
    end
  end

  assign ctl_o = ctl_q;
  assign rem_o = rem_q;
  assign den_o = den_q;
  assign quo_o = quo_q;

endmodule

FILE: hdl/trapezoid_fuzzy_membership.sv
`timescale 1ns / 1ps
// Pipeline: one classify stage, one stage per quotient bit of the slope
//   divider, one output register.
// Throughput: one word per cycle; the whole pipeline stalls together
//   only while the output word waits on m_axis_tready.
// Reset: async, active low; empties the pipeline and loads the
//   breakpoints a = 0, b = 0, c = 1.0, d = 1.0.
// ---------------------------------------------------------------------------
// trapezoid_fuzzy_membership
// Trapezoidal membership grade of a Q1.16 sample stream, breakpoints
// held in four write-only configuration registers.
// ---------------------------------------------------------------------------
`include "trapezoid_fuzzy_membership_macros.svh"

module trapezoid_fuzzy_membership #(
  parameter int unsigned FRAC_BITS = tfm_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration
  input  logic                                  cfg_we_i,
  input  logic [tfm_pkg::REG_IDX_W-1:0]         cfg_idx_i,
  input  logic [FRAC_BITS:0]                    cfg_data_i,
  // sample stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((FRAC_BITS + 8) / 8) * 8 - 1:0] s_axis_tdata,  // sample
  // grade stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [((FRAC_BITS + 8) / 8) * 8 - 1:0] m_axis_tdata   // grade
);
  import tfm_pkg::*;

  localparam int unsigned W  = FRAC_BITS + 1;
  localparam int unsigned TW = ((FRAC_BITS + 8) / 8) * 8;
  localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [W-1:0] a_q, b_q, c_q, d_q;
  logic         en;

  tfm_ctl_t               ctl_s [0:FRAC_BITS];
  logic [W-1:0]           rem_s [0:FRAC_BITS];
  logic [W-1:0]           den_s [0:FRAC_BITS];
  logic [FRAC_BITS-1:0]   quo_s [0:FRAC_BITS];

  logic         out_vld_d, out_vld_q;
  logic [W-1:0] grade_d, grade_q;

  // breakpoint registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
      b_q <= '0;
      c_q <= ONE;
      d_q <= ONE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LEFT_FOOT:      a_q <= cfg_data_i;
        REG_LEFT_SHOULDER:  b_q <= cfg_data_i;
        REG_RIGHT_SHOULDER: c_q <= cfg_data_i;
        REG_RIGHT_FOOT:     d_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline moves whenever the output register is free or being drained
  assign en            = ~out_vld_q | m_axis_tready;
  assign s_axis_tready = en;

  tfm_classify #(.FRAC_BITS(FRAC_BITS)) u_classify (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .x_i     (s_axis_tdata[W-1:0]),
    .a_i     (a_q),
    .b_i     (b_q),
    .c_i     (c_q),
    .d_i     (d_q),
    .ctl_o   (ctl_s[0]),
    .num_o   (rem_s[0]),
    .den_o   (den_s[0])
  );
  assign quo_s[0] = '0;

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_div
    tfm_div_stage #(.FRAC_BITS(FRAC_BITS)) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (ctl_s[i]),
      .rem_i  (rem_s[i]),
      .den_i  (den_s[i]),
      .quo_i  (quo_s[i]),
      .ctl_o  (ctl_s[i+1]),
      .rem_o  (rem_s[i+1]),
      .den_o  (den_s[i+1]),
      .quo_o  (quo_s[i+1])
    );
  end

  always_comb begin
    out_vld_d = ctl_s[FRAC_BITS].valid;
    case (ctl_s[FRAC_BITS].kind)
      KIND_ONE: grade_d = ONE;
      KIND_DIV: grade_d = {1'b0, quo_s[FRAC_BITS]};
      default:  grade_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      grade_q <= grade_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  always_comb begin
    m_axis_tdata        = '0;
    m_axis_tdata[W-1:0] = grade_q;
  end

  `TFM_ASSERT_NEVER(a_grade_max, m_axis_tvalid && (m_axis_tdata[W-1:0] > ONE))
  `TFM_ASSERT_NEVER(a_pad_zero, m_axis_tvalid && (m_axis_tdata[TW-1:W] != '0))
  `TFM_ASSERT(a_plateau_one, (en && ctl_s[FRAC_BITS].valid && ctl_s[FRAC_BITS].kind == KIND_ONE) |=> (m_axis_tvalid && m_axis_tdata[W-1:0] == ONE))
  `TFM_ASSERT(a_div_below_one, (en && ctl_s[FRAC_BITS].valid && ctl_s[FRAC_BITS].kind != KIND_ONE) |=> (m_axis_tvalid && m_axis_tdata[W-1] == 1'b0))

endmodule
